>>> hw/rtl/ahd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahd_pkg
// Shared types, constants and the FCS-16 byte update for the async HDLC
// deframer.
// ----------------------------------------------------------------------------
package ahd_pkg;

    localparam int MAX_FRAME_BYTES = 4095;
    localparam int LEN_W           = 12;
    localparam int LEN_FIELD_MAX   = (1 << LEN_W) - 1;

    // The count saturates at the smaller of the frame limit and the field range.
    localparam logic [LEN_W-1:0] COUNT_LIMIT =
        LEN_W'((MAX_FRAME_BYTES < LEN_FIELD_MAX) ? MAX_FRAME_BYTES : LEN_FIELD_MAX);

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [15:0] FCS_INIT   = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD   = 16'hF0B8;
    localparam logic [15:0] FCS_POLY   = 16'h8408;
    localparam logic [31:0] ACCM_RESET = 32'hFFFF_FFFF;
    localparam int          MIN_FRAME  = 4;

    // Configuration register index, taken from paddr[2].
    localparam logic REG_RX_ACCM = 1'b0;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_BADFCS = 2'd1,
        ST_ABORT  = 2'd2,
        ST_SHORT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             is_data;
        logic             frame_end;
        t_status          frame_status;
        logic [LEN_W-1:0] frame_length;
    } t_result;

    // Reflected CRC-16 update over one byte, one bit per step.
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs,
                                               input logic [7:0]  c);
        logic [15:0] f;
        f = fcs ^ {8'h00, c};
        for (int i = 0; i < 8; i++) begin
            if (f[0]) begin
                f = (f >> 1) ^ FCS_POLY;
            end else begin
                f = f >> 1;
            end
        end
        return f;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ahd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahd_core
// Frame state, destuffing, ACCM filtering and FCS check for one accepted
// byte per cycle; its result is presented combinationally.
// ----------------------------------------------------------------------------
module ahd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [31:0]     i_rx_accm,
    output ahd_pkg::t_result     o_result,
    output logic                 o_result_valid
);
    import ahd_pkg::*;

    logic             r_in_frame;
    logic             r_escape;
    logic [15:0]      r_fcs;
    logic [LEN_W-1:0] r_count;

    logic             n_in_frame;
    logic             n_escape;
    logic [15:0]      n_fcs;
    logic [LEN_W-1:0] n_count;

    logic       is_flag;
    logic       is_esc;
    logic       is_drop;
    logic [7:0] dest_byte;
    t_status    status;

    assign is_flag   = (i_rx_byte == FLAG_BYTE);
    assign is_esc    = (i_rx_byte == ESC_BYTE);
    assign is_drop   = (i_rx_byte < CTRL_LIMIT) && i_rx_accm[i_rx_byte[4:0]];
    assign dest_byte = i_rx_byte ^ (r_escape ? ESC_XOR : 8'h00);

    always_comb begin
        if (r_escape) begin
            status = ST_ABORT;
        end else if (r_count < LEN_W'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (r_fcs != FCS_GOOD) begin
            status = ST_BADFCS;
        end else begin
            status = ST_GOOD;
        end
    end

    always_comb begin
        n_in_frame     = r_in_frame;
        n_escape       = r_escape;
        n_fcs          = r_fcs;
        n_count        = r_count;
        o_result       = '0;
        o_result_valid = 1'b0;
        if (is_flag) begin
            if (r_in_frame) begin
                o_result_valid        = 1'b1;
                o_result.frame_end    = 1'b1;
                o_result.frame_status = status;
                o_result.frame_length = r_count;
                n_in_frame            = 1'b0;
                n_escape              = 1'b0;
                n_fcs                 = FCS_INIT;
                n_count               = '0;
            end
        end else begin
            n_in_frame = 1'b1;
            if (is_esc) begin
                n_escape = 1'b1;
            end else if (!is_drop) begin
                o_result_valid     = 1'b1;
                o_result.data_byte = dest_byte;
                o_result.is_data   = 1'b1;
                n_escape           = 1'b0;
                n_fcs              = fcs_update(r_fcs, dest_byte);
                if (r_count < COUNT_LIMIT) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
        if (!i_accept) begin
            o_result_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_escape   <= 1'b0;
            r_fcs      <= FCS_INIT;
            r_count    <= '0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_escape   <= n_escape;
            r_fcs      <= n_fcs;
            r_count    <= n_count;
        end
    end

    // A closing flag leaves the frame state fully cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.frame_end) |=>
            (!r_in_frame && !r_escape && r_fcs == FCS_INIT && r_count == '0))
        else $error("frame state not cleared after frame end");

    // Outside a frame no escape, count or partial FCS may linger.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (!r_escape && r_count == '0 && r_fcs == FCS_INIT))
        else $error("stale frame state while idle");

    // The length never passes its saturation limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_LIMIT)
        else $error("byte count above limit");

    // A data byte moves the count by at most one and clears the escape.
    a_data_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.is_data) |=>
            (!r_escape && (r_count == $past(r_count) + 1'b1 ||
                           r_count == COUNT_LIMIT)))
        else $error("data byte did not advance the frame state");

endmodule
`default_nettype wire

>>> hw/rtl/ahd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahd_out_buf
// Two-entry output register with skid stage, so the input side can hand
// over one more result while a result waits downstream.
// ----------------------------------------------------------------------------
module ahd_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ahd_pkg::t_result  i_result,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ahd_pkg::t_result       o_result
);
    import ahd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_main_valid) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/async_hdlc_deframer_fcs16_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// async_hdlc_deframer_fcs16_unit
// Async HDLC (PPP-style) receive deframer with FCS-16 check.
// ----------------------------------------------------------------------------
// Raw line bytes enter on the slave stream, one per transaction, and the
// block accepts one byte every clock cycle as long as its output buffer is
// not full; results are registered in the output buffer before they appear
// on the master stream. The frame state, the destuffing and the byte-wide FCS
// update all complete in the cycle the byte is accepted, which is what
// sets the one-byte-per-cycle rate. Escape bytes, opening flags and control
// bytes marked in rx_accm produce no result. Every other byte produces a
// data result (tuser = 1) carrying the destuffed byte, and a flag that
// closes a frame produces an end result (tuser = 0, tlast = 1) carrying the
// frame status and the destuffed length including the two FCS bytes. The
// status is good when the FCS residue is 0xF0B8, no escape is pending and
// the frame holds at least four bytes; the length saturates at 4095.
// rx_accm sits at APB address 0 and resets to all ones; write it only while
// the stream is idle.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_fcs16_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // APB configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                             // [21:10] frame_length, [23:22] zero
    output logic             m_axis_tlast,   // frame_end
    output logic             m_axis_tuser    // is_data
);
    import ahd_pkg::*;

    logic [31:0] r_rx_accm;
    logic        accept;
    logic        core_valid;
    t_result     core_result;
    t_result     out_result;

    // Configuration: pready is tied high, so each access completes in the
    // access phase. Only paddr[2] selects the register; writes above it are
    // ignored and read back as zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RX_ACCM) ? r_rx_accm : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_accm <= ACCM_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_RX_ACCM) begin
            r_rx_accm <= pwdata;
        end
    end

    // A byte is taken whenever the output buffer has room for its result.
    assign accept = s_axis_tvalid && s_axis_tready;

    ahd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (s_axis_tdata),
        .i_rx_accm      (r_rx_accm),
        .o_result       (core_result),
        .o_result_valid (core_valid)
    );

    ahd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (core_valid),
        .i_result (core_result),
        .o_space  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {2'b00, out_result.frame_length,
                           out_result.frame_status, out_result.data_byte};
    assign m_axis_tlast = out_result.frame_end;
    assign m_axis_tuser = out_result.is_data;

endmodule
`default_nettype wire

>>> tb/hdlc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_tb_pkg
// Helpers shared by the deframer stimulus and the deframer checker: the
// reflected FCS-16 byte update that both sides need.
// ----------------------------------------------------------------------------
package hdlc_tb_pkg;

    // Bit-serial form: the feedback bit is the low CRC bit against each data
    // bit, data taken LSB first.
    function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc,
                                                   input logic [7:0]  d);
        logic        fb;
        logic [15:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = {1'b0, acc[15:1]};
            if (fb) begin
                acc = acc ^ ahd_pkg::FCS_POLY;
            end
        end
        return acc;
    endfunction

endpackage

>>> tb/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the APB port and both streams of the deframer, predicts every
// result from the accepted line bytes and compares it field by field.
// ----------------------------------------------------------------------------
module deframer_checker
    import ahd_pkg::*;
    import hdlc_tb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,

    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,

    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    input  wire logic        i_m_tuser,

    output int               o_fail_count,
    output int               o_pending
);

    // Shadow of the receive state.
    logic [31:0]      accm_shadow;
    logic             in_frame;
    logic             esc_pending;
    logic [15:0]      fcs_acc;
    logic [LEN_W-1:0] frame_bytes;

    t_result results_due[$];
    int      mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        t_result    r;
        logic [7:0] c;
        r = '0;
        if (b == FLAG_BYTE) begin
            if (!in_frame) begin
                return;
            end
            r.frame_end = 1'b1;
            if (esc_pending) begin
                r.frame_status = ST_ABORT;
            end else if (frame_bytes < MIN_FRAME) begin
                r.frame_status = ST_SHORT;
            end else if (fcs_acc != FCS_GOOD) begin
                r.frame_status = ST_BADFCS;
            end else begin
                r.frame_status = ST_GOOD;
            end
            r.frame_length = frame_bytes;
            results_due.push_back(r);
            in_frame    = 1'b0;
            esc_pending = 1'b0;
            fcs_acc     = FCS_INIT;
            frame_bytes = '0;
            return;
        end
        in_frame = 1'b1;
        if (b == ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
        end
        // Raw control bytes masked by the ACCM produce no result, but still open a frame.
        if (b < CTRL_LIMIT && accm_shadow[b[4:0]]) begin
            return;
        end
        c           = esc_pending ? (b ^ ESC_XOR) : b;
        esc_pending = 1'b0;
        fcs_acc     = crc16_x25_byte(fcs_acc, c);
        if (frame_bytes < COUNT_LIMIT) begin
            frame_bytes++;
        end
        r.data_byte = c;
        r.is_data   = 1'b1;
        results_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            accm_shadow = ACCM_RESET;
            in_frame    = 1'b0;
            esc_pending = 1'b0;
            fcs_acc     = FCS_INIT;
            frame_bytes = '0;
            results_due.delete();
            mismatches  = 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_RX_ACCM) begin
                if (i_pwrite) begin
                    accm_shadow = i_pwdata;
                end else if (i_prdata != accm_shadow) begin
                    report_mismatch($sformatf("rx_accm read: expected %h, got %h",
                                              accm_shadow, i_prdata));
                end
            end

            // Results are registered in the output buffer before they leave, so compare
            // before predicting the byte taken at this same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: byte %h user %b last %b status %0d len %0d",
                        i_m_tdata[7:0], i_m_tuser, i_m_tlast, i_m_tdata[9:8],
                        i_m_tdata[21:10]));
                end else begin
                    exp_r = results_due.pop_front();
                    if (exp_r.data_byte != i_m_tdata[7:0] || exp_r.is_data != i_m_tuser ||
                        exp_r.frame_end != i_m_tlast ||
                        exp_r.frame_status != i_m_tdata[9:8] ||
                        exp_r.frame_length != i_m_tdata[21:10] ||
                        i_m_tdata[23:22] != 2'b00) begin
                        report_mismatch($sformatf(
                            {"result mismatch: expected byte %h user %b last %b status %0d",
                             " len %0d, got byte %h user %b last %b status %0d len %0d",
                             " pad %b"},
                            exp_r.data_byte, exp_r.is_data, exp_r.frame_end,
                            exp_r.frame_status, exp_r.frame_length,
                            i_m_tdata[7:0], i_m_tuser, i_m_tlast, i_m_tdata[9:8],
                            i_m_tdata[21:10], i_m_tdata[23:22]));
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata);
            end
        end
        o_pending    = results_due.size();
        o_fail_count = mismatches;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the async HDLC deframer with FCS-16 check.
// ----------------------------------------------------------------------------
// A short directed run covers idle flags, escape-then-flag aborts, frames
// started by a masked control byte, short frames, escaped specials and a
// double escape. The random part then sends mostly well-formed frames
// (correct FCS, random byte stuffing, stray masked control bytes) mixed
// with corrupted FCS, aborts and raw line noise, under several ACCM
// settings including all ones and all zeros. A checker beside the block
// predicts every result and counts mismatches; this module only drives and
// decides.
// ----------------------------------------------------------------------------
module testbench;
    import ahd_pkg::*;
    import hdlc_tb_pkg::*;

    localparam int TOTAL_ITEMS = 950;

    // Directed line bytes, sent from the most significant byte down.
    localparam int          N_DIRECTED = 20;
    localparam logic [8*N_DIRECTED-1:0] DIRECTED_BYTES = {
        8'h7E,                                  // flag while idle: nothing
        8'h7D, 8'h7E,                           // escape opens frame, flag aborts
        8'h01, 8'h7E,                           // masked control opens frame, short
        8'hFF, 8'h7E,                           // one byte, short
        8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h20, // escaped flag, escape, NUL
        8'h1F, 8'h20,                           // masked control dropped, 0x20 kept
        8'h7D, 8'h7D, 8'h41, 8'h7E,             // double escape, then close
        8'h7E                                   // idle flag again
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] data_byte, [9:8] frame_status,
                                       // [21:10] frame_length, [23:22] zero
    logic        m_axis_tlast;         // frame_end
    logic        m_axis_tuser;         // is_data

    int          fail_count;
    int          results_pending;

    // Stimulus bookkeeping.
    logic [31:0] accm_now = ACCM_RESET;
    int          bytes_sent = 0;
    int          src_burst = 0;
    int          sink_burst = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    async_hdlc_deframer_fcs16_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    deframer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // Idle cycles before the next transaction on one side. Now and then a
    // stretch of back-to-back transactions is started instead.
    function automatic int next_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // One line byte. The task returns right after the accepting edge with
    // tvalid still high; the next call (or the idle wait) changes or drops it
    // at the following falling edge, before the next rising edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = next_gap(src_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Builds a frame with a correct FCS (unless corrupted), stuffs it the way
    // a sender under the current ACCM would, and optionally escapes extra
    // bytes and sprinkles masked control bytes that the receiver drops.
    task automatic send_frame(input int n, input bit bad_fcs, input bit abort_tail,
                              input bit open_flag);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [7:0]  b;
        logic [4:0]  ctl;
        crc = FCS_INIT;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 6))
                    0:       b = FLAG_BYTE;
                    1:       b = ESC_BYTE;
                    2:       b = FLAG_BYTE ^ ESC_XOR;
                    3:       b = ESC_BYTE ^ ESC_XOR;
                    4:       b = 8'h00;
                    5:       b = CTRL_LIMIT - 8'd1;
                    default: b = CTRL_LIMIT;
                endcase
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            body.push_back(b);
            crc = crc16_x25_byte(crc, b);
        end
        crc = ~crc;
        if (bad_fcs) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);

        if (open_flag) begin
            send_byte(FLAG_BYTE);
        end
        foreach (body[k]) begin
            if ($urandom_range(0, 9) == 0) begin
                ctl = 5'($urandom_range(0, 31));
                if (accm_now[ctl]) begin
                    send_byte({3'b000, ctl});
                end
            end
            b = body[k];
            // Escaping a byte that would turn into a flag or an escape after
            // the XOR is not legal stuffing, so those are never escaped at will.
            if (b == FLAG_BYTE || b == ESC_BYTE || (b < CTRL_LIMIT && accm_now[b[4:0]]) ||
                ($urandom_range(0, 15) == 0 && b != (FLAG_BYTE ^ ESC_XOR) &&
                 b != (ESC_BYTE ^ ESC_XOR))) begin
                send_byte(ESC_BYTE);
                send_byte(b ^ ESC_XOR);
            end else begin
                send_byte(b);
            end
        end
        if (abort_tail) begin
            send_byte(ESC_BYTE);
        end
        send_byte(FLAG_BYTE);
    endtask

    // Drop tvalid, wait for every predicted result, then let the pipeline
    // drain bytes that produce no result.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_RX_ACCM, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_accm(input logic [31:0] value);
        apb_access(1'b1, value);
        accm_now = value;
        apb_access(1'b0, '0);
    endtask

    // Result side: random stalls before each result, with stretches of none.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = next_gap(sink_burst);
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int          phase;
        int          kind;
        int          n;
        int          n_frames;
        logic [31:0] accm_val;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // The reset value of rx_accm must read back before any write.
        apb_access(1'b0, '0);

        // Directed part under the reset ACCM (all control bytes masked).
        for (int k = N_DIRECTED - 1; k >= 0; k--) begin
            send_byte(DIRECTED_BYTES[8*k +: 8]);
        end
        send_frame(2, 1'b0, 1'b0, 1'b1);    // shortest frame that can be good
        send_frame(3, 1'b1, 1'b0, 1'b0);    // corrupted FCS
        wait_idle();

        // Random part, one ACCM setting per phase; the extremes come first.
        // It stops after the frame that reaches the byte budget.
        phase = 0;
        while (bytes_sent < TOTAL_ITEMS) begin
            case (phase % 5)
                0:       accm_val = ACCM_RESET;
                1:       accm_val = '0;
                2:       accm_val = 32'h0000_0001 << $urandom_range(0, 31);
                default: accm_val = $urandom;
            endcase
            set_accm(accm_val);
            n_frames = $urandom_range(8, 16);
            for (int f = 0; f < n_frames && bytes_sent < TOTAL_ITEMS; f++) begin
                kind = $urandom_range(0, 9);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(0, 12);
                case (kind) inside
                    [0:5]: send_frame(n, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
                    6:     send_frame(n, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    7:     send_frame(n, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
                    8: begin
                        // Raw noise: every bit pattern of the line byte.
                        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        // Noise weighted toward the special codes.
                        repeat ($urandom_range(1, 8)) begin
                            case ($urandom_range(0, 4))
                                0:       send_byte(FLAG_BYTE);
                                1:       send_byte(ESC_BYTE);
                                2:       send_byte(8'($urandom_range(0, 31)));
                                3:       send_byte(CTRL_LIMIT);
                                default: send_byte(8'($urandom_range(0, 255)));
                            endcase
                        end
                    end
                endcase
            end
            wait_idle();
            phase++;
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
